### rtl/adcscan_pkg.sv
// Shared constants, types and codes of the ADC channel scanner.
package adcscan_pkg;

	// Scan geometry
	localparam int CHANNELS = 8;
	localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Field widths
	localparam int OP_W     = 1;
	localparam int SAMPLE_W = 10;
	localparam int CHAN_W   = 3;
	localparam int NARROW_W = 8;
	localparam int KEEP_W   = 9;
	localparam int CFG_W    = 9;
	localparam int CFG_IDX_W = 1;

	// Average in Q8: 10 integer bits, 8 fraction bits
	localparam int AVG_FRAC = 8;
	localparam int AVG_W    = SAMPLE_W + AVG_FRAC;
	localparam int RAM_W    = SAMPLE_W + AVG_W;

	// Multiply-add widths
	localparam int PROD_OLD_W = AVG_W + KEEP_W;
	localparam int PROD_NEW_W = SAMPLE_W + KEEP_W;
	localparam int SUM_W      = PROD_OLD_W + 1;
	localparam int ROUND_W    = AVG_W + 1;

	localparam int KEEP_ONE   = 256;
	localparam int ROUND_HALF = 128;
	localparam int VALUE_MAX  = 1023;

	// Register reset values
	localparam logic       FILTER_ENABLE_RST = 1'b1;
	localparam logic [KEEP_W-1:0] KEEP_WEIGHT_RST = 9'd230;

	// Operation codes
	localparam logic [OP_W-1:0] OP_CONVERT = 1'b0;
	localparam logic [OP_W-1:0] OP_READ    = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_WEIGHT   = 1'b1;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_CALC
	} state_t;

endpackage

### rtl/adc_channel_scanner_with_smoothing_core.sv
// Top level of the round-robin ADC scanner with per-channel smoothing.
//
// A beat is taken when start is high and busy is low. Every beat, conversion
// or read, reads its channel's memory word as it is taken; the fetch state
// forms the two registered products of the smoothing filter; the calc state
// adds them and, on a conversion, writes the word back. The result appears
// on the cycle after that, marked by done for exactly one cycle, and cannot
// be held off; busy is already low in that cycle, so a new beat can follow,
// but not before. Conversions return zero values with mux_select naming the
// next channel to scan. Registers may be written only while busy is low.
module adc_channel_scanner_with_smoothing_core
	import adcscan_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Command
	input  logic                  start,
	output logic                  busy,
	input  logic [OP_W-1:0]       operation,
	input  logic [SAMPLE_W-1:0]   sample,
	input  logic [CHAN_W-1:0]     read_channel,
	// Result
	output logic                  done,
	output logic [SAMPLE_W-1:0]   value_wide,
	output logic [NARROW_W-1:0]   value_narrow,
	output logic                  fresh,
	output logic [CHAN_W-1:0]     mux_select,
	// Configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata
);

	state_t state_q, state_d;

	logic              filter_enable_q;
	logic [KEEP_W-1:0] keep_weight_q;

	logic [CH_AW-1:0]    scan_q;
	logic [CHANNELS-1:0] fresh_q, seeded_q, written_q;

	logic                accept;
	logic [CH_AW-1:0]    raddr;
	logic [RAM_W-1:0]    rdata;
	logic                ram_we;
	logic [RAM_W-1:0]    ram_wdata;

	// Beat held through the sequence
	logic [OP_W-1:0]     op_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [CH_AW-1:0]    addr_s1;
	logic                chan_ok_s1;

	// Fetch stage results
	logic [PROD_OLD_W-1:0] prod_old_s2;
	logic [PROD_NEW_W-1:0] prod_new_s2;
	logic [AVG_W-1:0]      avg_old_s2;
	logic [SAMPLE_W-1:0]   value_s2;

	logic [SAMPLE_W-1:0] raw_rd;
	logic [AVG_W-1:0]    avg_rd;
	logic [KEEP_W-1:0]   keep_sat;
	logic [KEEP_W-1:0]   weight_new;
	logic [ROUND_W-1:0]  round_sum;
	logic [ROUND_W-AVG_FRAC-1:0] rounded;
	logic [SAMPLE_W-1:0] rounded_sat;
	logic [SAMPLE_W-1:0] value_rd;

	logic [SUM_W-1:0]    sum;
	logic [AVG_W-1:0]    avg_new;
	logic [CH_AW-1:0]    scan_next;
	logic                calc;

	// Result registers
	logic                done_q;
	logic [SAMPLE_W-1:0] value_wide_q;
	logic                fresh_out_q;
	logic [CHAN_W-1:0]   mux_select_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (start) state_d = ST_FETCH;
			ST_FETCH: state_d = ST_CALC;
			ST_CALC:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		busy = 1'b1;
		calc = 1'b0;
		case (state_q)
			ST_IDLE:  busy = 1'b0;
			ST_FETCH: busy = 1'b1;
			ST_CALC:  calc = 1'b1;
			default:  busy = 1'b1;
		endcase
	end

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_enable_q <= FILTER_ENABLE_RST;
			keep_weight_q   <= KEEP_WEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FILTER_ENABLE: filter_enable_q <= cfg_wdata[0];
				REG_KEEP_WEIGHT:   keep_weight_q   <= cfg_wdata[KEEP_W-1:0];
				default:           ;
			endcase
		end
	end

	// Channel memory: raw sample over Q8 average
	assign raddr = (operation == OP_READ) ? CH_AW'(read_channel) : scan_q;

	adcscan_ram #(
		.WIDTH (RAM_W),
		.DEPTH (CHANNELS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (ram_wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Latch the accepted beat
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= operation;
			sample_s1  <= sample;
			addr_s1    <= raddr;
			chan_ok_s1 <= (operation == OP_CONVERT) ||
				(32'(read_channel) < CHANNELS);
		end
	end

	// Fetch: split the word, form products and the read value
	assign raw_rd     = rdata[AVG_W +: SAMPLE_W];
	assign avg_rd     = rdata[AVG_W-1:0];
	assign keep_sat   = (keep_weight_q > KEEP_W'(KEEP_ONE)) ? KEEP_W'(KEEP_ONE) : keep_weight_q;
	assign weight_new = KEEP_W'(KEEP_ONE) - keep_sat;
	assign round_sum  = ROUND_W'(avg_rd) + ROUND_W'(ROUND_HALF);
	assign rounded    = round_sum[ROUND_W-1:AVG_FRAC];
	assign rounded_sat = (rounded > (ROUND_W-AVG_FRAC)'(VALUE_MAX)) ?
		SAMPLE_W'(VALUE_MAX) : rounded[SAMPLE_W-1:0];

	always_comb begin
		value_rd = '0;
		if (chan_ok_s1) begin
			if (filter_enable_q) begin
				if (seeded_q[addr_s1]) value_rd = rounded_sat;
			end else if (written_q[addr_s1]) begin
				value_rd = raw_rd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FETCH) begin
			prod_old_s2 <= PROD_OLD_W'(avg_rd) * PROD_OLD_W'(keep_sat);
			prod_new_s2 <= PROD_NEW_W'(sample_s1) * PROD_NEW_W'(weight_new);
			avg_old_s2  <= avg_rd;
			value_s2    <= value_rd;
		end
	end

	// Calc: add and truncate, seed or keep the average; write back on a conversion
	assign sum = SUM_W'(prod_old_s2) + SUM_W'({prod_new_s2, {AVG_FRAC{1'b0}}});

	always_comb begin
		avg_new = avg_old_s2;
		if (filter_enable_q) begin
			if (!seeded_q[addr_s1]) avg_new = {sample_s1, {AVG_FRAC{1'b0}}};
			else                    avg_new = sum[AVG_FRAC +: AVG_W];
		end
	end

	assign ram_we    = calc && (op_s1 == OP_CONVERT);
	assign ram_wdata = {sample_s1, avg_new};
	assign scan_next = (32'(scan_q) == CHANNELS - 1) ? '0 : scan_q + 1'b1;

	// Advance the scan and update the channel flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			fresh_q   <= '0;
			seeded_q  <= '0;
			written_q <= '0;
		end else if (calc) begin
			if (op_s1 == OP_CONVERT) begin
				scan_q             <= scan_next;
				fresh_q[addr_s1]   <= 1'b1;
				written_q[addr_s1] <= 1'b1;
				if (filter_enable_q) seeded_q[addr_s1] <= 1'b1;
			end else if (chan_ok_s1) begin
				fresh_q[addr_s1] <= 1'b0;
			end
		end
	end

	// Drive the result beat for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= calc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_wide_q <= '0;
			fresh_out_q  <= 1'b0;
			mux_select_q <= '0;
		end else if (calc) begin
			if (op_s1 == OP_CONVERT) begin
				value_wide_q <= '0;
				fresh_out_q  <= 1'b0;
				mux_select_q <= CHAN_W'(scan_next);
			end else begin
				value_wide_q <= value_s2;
				fresh_out_q  <= chan_ok_s1 && fresh_q[addr_s1];
				mux_select_q <= CHAN_W'(scan_q);
			end
		end
	end

	assign done         = done_q;
	assign value_wide   = value_wide_q;
	assign value_narrow = value_wide_q[SAMPLE_W-1 -: NARROW_W];
	assign fresh        = fresh_out_q;
	assign mux_select   = mux_select_q;

endmodule

### rtl/adcscan_ram.sv
// Generic single-port-write, registered-read RAM.
module adcscan_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one entry, register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/adcscan_chk.sv
// Port-level checker for the ADC scanner, bound to the top level.
module adcscan_chk
	import adcscan_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic [SAMPLE_W-1:0] value_wide,
	input logic [NARROW_W-1:0] value_narrow,
	input logic [CHAN_W-1:0]   mux_select
);

	// Result beat shows only once the sequence has finished
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// Accepted beat holds the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted beat");

	// Every accepted beat yields its result beat
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result beat missing");

	// Narrow value tracks the wide one
	a_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (value_narrow == value_wide[SAMPLE_W-1 -: NARROW_W]))
		else $error("narrow value mismatch");

	// Scan pointer moves only with a result beat
	a_scan_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(mux_select))
		else $error("mux_select changed without result beat");

endmodule

bind adc_channel_scanner_with_smoothing_core adcscan_chk u_adcscan_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.value_wide   (value_wide),
	.value_narrow (value_narrow),
	.mux_select   (mux_select)
);
